### hw/rtl/accel_magnitude_step_counter_unit_assert.svh
// assertion macros used by the step counter port checker
`ifndef ACCEL_MAGNITUDE_STEP_COUNTER_UNIT_ASSERT_SVH
`define ACCEL_MAGNITUDE_STEP_COUNTER_UNIT_ASSERT_SVH

// property checked on each clock edge outside reset
`define AMSC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on each clock edge, reset included
`define AMSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/amsc_pkg.sv
// types and constants of the accelerometer step counter
package amsc_pkg;

  // step counter width
  localparam int unsigned COUNT_BITS = 16;

  // serial datapath sizes
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned SQR_STEPS  = 8;   // two multiplier bits per cycle
  localparam int unsigned ROOT_STEPS = 16;  // one root bit per cycle
  localparam int unsigned CNT_W      = $clog2(ROOT_STEPS);
  localparam int unsigned NUM_AXES   = 3;

  // configuration port
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam logic [15:0] THRESHOLD_RST = 16'd491;
  localparam logic        REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               reset_pressed;
    logic               toggle_pressed;
  } in_item_t;

  typedef struct packed {
    logic [15:0] step_count;
    logic        running;
    logic        step_detected;
  } out_item_t;

  // magnitude of a two's complement axis value
  function automatic logic [AXIS_W-1:0] abs_axis(input logic signed [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] r;
    r = v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
    return r;
  endfunction

endpackage

### hw/rtl/accel_magnitude_step_counter_unit.sv
// accelerometer magnitude step counter, top level
//
//  channel | dir | handshake                | payload
//  in      | in  | in_valid_i / in_stall_o   | in_item_i  (amsc_pkg::in_item_t)
//  out     | out | out_valid_o / out_stall_i | out_item_o (amsc_pkg::out_item_t)
//  cfg     | in  | psel/penable/pwrite       | paddr, pwdata, prdata
//
// an item that computes a magnitude goes through accept, squaring (three
// radix-4 shift-add lanes), sum, square root (one root bit per cycle) and
// result; an item with reset pressed or while stopped goes from accept to result
// the output register holds one result, so a new item is taken while it waits
// reset clears the count, the running flag, the stored magnitude and the
// threshold (to 491)
module accel_magnitude_step_counter_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  amsc_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output amsc_pkg::out_item_t                out_item_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [amsc_pkg::PADDR_W-1:0]       paddr,
  input  logic [amsc_pkg::PDATA_W-1:0]       pwdata,
  output logic [amsc_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQR  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  localparam int unsigned RootW = amsc_pkg::MAG_W;
  localparam int unsigned RemW  = RootW + 1;

  state_e state_q, state_d;
  logic   in_root_q;

  // architectural state
  logic [amsc_pkg::COUNT_BITS-1:0] step_q;
  logic                            run_q;
  logic [amsc_pkg::MAG_W-1:0]      last_q;
  logic [15:0]                     thr_q;

  // latched item controls
  logic rst_btn_q;
  logic run_new_q;
  logic compute_q;

  // squaring lanes
  logic [amsc_pkg::SQ_W-1:0]   mcand_q [amsc_pkg::NUM_AXES];
  logic [amsc_pkg::AXIS_W-1:0] mplier_q[amsc_pkg::NUM_AXES];
  logic [amsc_pkg::SQ_W-1:0]   acc_q   [amsc_pkg::NUM_AXES];
  logic [amsc_pkg::SQ_W-1:0]   acc_d   [amsc_pkg::NUM_AXES];
  logic [amsc_pkg::AXIS_W-1:0] abs_in  [amsc_pkg::NUM_AXES];

  // square root
  logic [amsc_pkg::SQ_W-1:0] rad_q;
  logic [RemW-1:0]           rem_q;
  logic [RootW-1:0]          root_q;
  logic [RemW+1:0]           rem_sh;
  logic [RemW+1:0]           trial;
  logic                      take;

  logic [amsc_pkg::CNT_W-1:0] cnt_q;

  // output register
  logic                out_valid_q;
  amsc_pkg::out_item_t out_q;

  logic accept;
  logic out_free;
  logic finish;
  logic cfg_wr;
  logic rise_hit;
  logic not_sat;
  logic compute_in;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || in_root_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == ST_FIN) && out_free;
  assign compute_in = !in_item_i.reset_pressed && (run_q ^ in_item_i.toggle_pressed);

  assign abs_in[0] = amsc_pkg::abs_axis(in_item_i.accel_x);
  assign abs_in[1] = amsc_pkg::abs_axis(in_item_i.accel_y);
  assign abs_in[2] = amsc_pkg::abs_axis(in_item_i.accel_z);

  // radix-4 partial product per lane
  always_comb begin
    for (int i = 0; i < amsc_pkg::NUM_AXES; i++) begin
      acc_d[i] = acc_q[i]
               + (mplier_q[i][0] ? mcand_q[i] : '0)
               + (mplier_q[i][1] ? {mcand_q[i][amsc_pkg::SQ_W-2:0], 1'b0} : '0);
    end
  end

  // restoring root step: bring down two radicand bits, try (root << 2) | 1
  assign rem_sh = {rem_q, rad_q[amsc_pkg::SQ_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign take   = rem_sh >= trial;

  // sequencer; the root phase runs in ST_IDLE while the flag in_root_q is set
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_root_q) begin
          if (cnt_q == amsc_pkg::CNT_W'(amsc_pkg::ROOT_STEPS - 1)) state_d = ST_FIN;
        end else if (accept) begin
          state_d = compute_in ? ST_SQR : ST_FIN;
        end
      end
      ST_SQR: begin
        if (cnt_q == amsc_pkg::CNT_W'(amsc_pkg::SQR_STEPS - 1)) state_d = ST_SUM;
      end
      ST_SUM:  state_d = ST_IDLE;
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_root_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SUM) begin
        in_root_q <= 1'b1;
      end else if (in_root_q &&
                   cnt_q == amsc_pkg::CNT_W'(amsc_pkg::ROOT_STEPS - 1)) begin
        in_root_q <= 1'b0;
      end
      if (state_q != state_d || state_q == ST_SUM) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // item latch, squaring lanes and root datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rst_btn_q <= in_item_i.reset_pressed;
      run_new_q <= run_q ^ in_item_i.toggle_pressed;
      compute_q <= compute_in;
      for (int i = 0; i < amsc_pkg::NUM_AXES; i++) begin
        mcand_q[i]  <= amsc_pkg::SQ_W'(abs_in[i]);
        mplier_q[i] <= abs_in[i];
        acc_q[i]    <= '0;
      end
    end else if (state_q == ST_SQR) begin
      for (int i = 0; i < amsc_pkg::NUM_AXES; i++) begin
        mcand_q[i]  <= {mcand_q[i][amsc_pkg::SQ_W-3:0], 2'b00};
        mplier_q[i] <= {2'b00, mplier_q[i][amsc_pkg::AXIS_W-1:2]};
        acc_q[i]    <= acc_d[i];
      end
    end
    if (state_q == ST_SUM) begin
      rad_q  <= acc_q[0] + acc_q[1] + acc_q[2];
      rem_q  <= '0;
      root_q <= '0;
    end else if (in_root_q) begin
      rad_q  <= {rad_q[amsc_pkg::SQ_W-3:0], 2'b00};
      rem_q  <= take ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_q <= {root_q[RootW-2:0], take};
    end
  end

  // step decision: rise = mag - last > threshold
  assign rise_hit = {1'b0, root_q} > ({1'b0, last_q} + {1'b0, thr_q});
  assign not_sat  = step_q != '1;

  // architectural state and threshold register
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      run_q  <= 1'b0;
      last_q <= '0;
      thr_q  <= amsc_pkg::THRESHOLD_RST;
    end else begin
      if (cfg_wr && paddr[2] == amsc_pkg::REG_THRESHOLD) begin
        thr_q <= pwdata[15:0];
      end
      if (finish) begin
        if (rst_btn_q) begin
          step_q <= '0;
        end else begin
          run_q <= run_new_q;
          if (compute_q) begin
            last_q <= root_q;
            if (rise_hit && not_sat) step_q <= step_q + 1'b1;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      if (rst_btn_q) begin
        out_q.step_count    <= '0;
        out_q.running       <= run_q;
        out_q.step_detected <= 1'b0;
      end else begin
        out_q.running       <= run_new_q;
        out_q.step_detected <= compute_q && rise_hit && not_sat;
        if (compute_q && rise_hit && not_sat) begin
          out_q.step_count <= 16'(step_q + 1'b1);
        end else begin
          out_q.step_count <= 16'(step_q);
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // register read
  assign pready = 1'b1;
  assign prdata = (paddr[2] == amsc_pkg::REG_THRESHOLD)
                ? amsc_pkg::PDATA_W'(thr_q) : '0;

endmodule

### hw/rtl/amsc_checker.sv
// port-level checker for the step counter, bound to the top level
`include "accel_magnitude_step_counter_unit_assert.svh"

module amsc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input amsc_pkg::out_item_t           out_item_o,
  input logic                          pready
);

  // a held result stays valid
  `AMSC_ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")

  // an accepted item keeps the block busy for the next cycle
  `AMSC_ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "item taken on consecutive cycles")

  // a step only counts while running
  `AMSC_ASSERT_RST(a_step_running, clk_i, rst_ni, out_valid_o && out_item_o.step_detected |-> out_item_o.running, "step reported while stopped")

  // a counted step leaves a nonzero count
  `AMSC_ASSERT_RST(a_step_count, clk_i, rst_ni, out_valid_o && out_item_o.step_detected |-> out_item_o.step_count != 16'd0, "step with zero count")

  // register port never waits
  `AMSC_ASSERT_ALWAYS(a_pready, clk_i, pready, "register port not ready")

endmodule

bind accel_magnitude_step_counter_unit amsc_checker u_amsc_checker (.*);

### verif/accel_magnitude_step_counter_checker.sv
// checker: predicts each step counter result and compares it with the block
module accel_magnitude_step_counter_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  amsc_pkg::in_item_t           in_item_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  amsc_pkg::out_item_t          out_item_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [amsc_pkg::PADDR_W-1:0] paddr_i,
  input  logic [amsc_pkg::PDATA_W-1:0] pwdata_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);

  localparam logic [amsc_pkg::PADDR_W-1:0] THRESHOLD_ADDR =
    amsc_pkg::PADDR_W'(4 * amsc_pkg::REG_THRESHOLD);
  localparam int                 REPORT_LIMIT   = 10;
  localparam logic [amsc_pkg::COUNT_BITS-1:0] COUNT_TOP = '1;

  // shadow of the block state and its threshold register
  logic [15:0]                     rise_thr;
  logic [amsc_pkg::COUNT_BITS-1:0] step_total;
  logic                            run_flag;
  logic [amsc_pkg::MAG_W-1:0]      last_mag;
  int                              misses;
  amsc_pkg::out_item_t             expected_counts[$];

  // floor square root, settled one root bit at a time from the top
  function automatic logic [amsc_pkg::MAG_W-1:0] floor_root(input logic [31:0] energy);
    logic [amsc_pkg::MAG_W-1:0] root;
    logic [amsc_pkg::MAG_W-1:0] trial;
    root = '0;
    for (int b = amsc_pkg::MAG_W - 1; b >= 0; b--) begin
      trial = root | (amsc_pkg::MAG_W'(1) << b);
      if (32'(trial) * 32'(trial) <= energy) root = trial;
    end
    return root;
  endfunction

  // advance the shadow state by one item and form its result
  task automatic count_sample(input amsc_pkg::in_item_t smp, output amsc_pkg::out_item_t res);
    logic signed [31:0]         ax, ay, az;
    logic [31:0]                energy;
    logic [amsc_pkg::MAG_W-1:0] mag;
    int                         rise;
    logic                       hit;
    hit = 1'b0;
    if (smp.reset_pressed) begin
      step_total = '0;
    end else begin
      if (smp.toggle_pressed) run_flag = ~run_flag;
      if (run_flag) begin
        ax = $signed(smp.accel_x);
        ay = $signed(smp.accel_y);
        az = $signed(smp.accel_z);
        // each square is below 2^31, the sum fits 32 unsigned bits
        energy = ax * ax + ay * ay + az * az;
        mag = floor_root(energy);
        rise = int'(mag) - int'(last_mag);
        if (rise > int'(rise_thr) && step_total != COUNT_TOP) begin
          step_total = step_total + 1'b1;
          hit = 1'b1;
        end
        last_mag = mag;
      end
    end
    res.step_count    = 16'(step_total);
    res.running       = run_flag;
    res.step_detected = hit;
  endtask

  // watch the register port and both channels
  always @(posedge clk_i or negedge rst_ni) begin : track
    amsc_pkg::out_item_t want;
    amsc_pkg::out_item_t pred;
    if (!rst_ni) begin
      rise_thr   = amsc_pkg::THRESHOLD_RST;
      step_total = '0;
      run_flag   = 1'b0;
      last_mag   = '0;
      misses     = 0;
      expected_counts.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == THRESHOLD_ADDR)
        rise_thr = pwdata_i[15:0];
      // results are registered and leave after their item is taken, so compare first
      if (out_valid_i && !out_stall_i) begin
        if (expected_counts.size() == 0) begin
          if (misses < REPORT_LIMIT)
            $display("unexpected result: count %0d running %0b step %0b",
                     out_item_i.step_count, out_item_i.running, out_item_i.step_detected);
          misses++;
        end else begin
          want = expected_counts.pop_front();
          if (out_item_i.step_count !== want.step_count ||
              out_item_i.running !== want.running ||
              out_item_i.step_detected !== want.step_detected) begin
            if (misses < REPORT_LIMIT)
              $display({"result mismatch: expected count %0d running %0b step %0b, ",
                        "got count %0d running %0b step %0b"},
                       want.step_count, want.running, want.step_detected,
                       out_item_i.step_count, out_item_i.running, out_item_i.step_detected);
            misses++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        count_sample(in_item_i, pred);
        expected_counts.push_back(pred);
      end
      mismatch_count_o <= misses;
      pending_o        <= expected_counts.size();
    end
  end

endmodule

### verif/tb_accel_magnitude_step_counter_unit.sv
// testbench top: stimulus, register writes, receiver stalls and verdict
module tb_accel_magnitude_step_counter_unit;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  localparam logic [amsc_pkg::PADDR_W-1:0] THRESHOLD_ADDR =
    amsc_pkg::PADDR_W'(4 * amsc_pkg::REG_THRESHOLD);
  localparam int IDLE_LIMIT     = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 744;
  localparam int PHASES         = 6;
  // a short climb of one axis at full rate, one step per item after the first
  localparam int RAMP_ITEMS     = 40;
  localparam int RAMP_STEP      = 700;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  amsc_pkg::in_item_t            in_item_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  amsc_pkg::out_item_t           out_item_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [amsc_pkg::PADDR_W-1:0]  paddr;
  logic [amsc_pkg::PDATA_W-1:0]  pwdata;
  logic [amsc_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  int                  mismatch_count;
  int                  pending;
  logic                run_shadow;
  logic                full_rate;
  stall_mode_e         stall_mode;
  int                  mode_left;
  int                  idle_cycles;

  accel_magnitude_step_counter_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  accel_magnitude_step_counter_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_item_i        (in_item_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_item_i       (out_item_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stalls, switching between patterns of random length
  always @(posedge clk_i) begin
    if (!rst_ni || full_rate) begin
      out_stall_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(16, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HALF:  out_stall_i <= ($urandom_range(0, 1) == 0);
        default:     out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL accel_magnitude_step_counter_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic amsc_pkg::in_item_t make_item(input logic signed [15:0] x,
                                                   input logic signed [15:0] y,
                                                   input logic signed [15:0] z,
                                                   input logic rst_press,
                                                   input logic tog_press);
    amsc_pkg::in_item_t smp;
    smp.accel_x        = x;
    smp.accel_y        = y;
    smp.accel_z        = z;
    smp.reset_pressed  = rst_press;
    smp.toggle_pressed = tog_press;
    return smp;
  endfunction

  // value spread evenly around a centre
  function automatic logic signed [15:0] near(input int centre, input int spread);
    int off;
    off = int'($urandom_range(0, 2 * spread)) - spread;
    return 16'(centre + off);
  endfunction

  function automatic logic signed [15:0] axis_extreme();
    case ($urandom_range(0, 4))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // mostly gravity plus a walking swing, some raw noise, extremes and zero samples
  function automatic amsc_pkg::in_item_t gait_sample();
    amsc_pkg::in_item_t smp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        smp.accel_x = near(0, 2000);
        smp.accel_y = near(0, 2000);
        smp.accel_z = near(16384, 6000);
      end
      6, 7: begin
        smp.accel_x = 16'($urandom);
        smp.accel_y = 16'($urandom);
        smp.accel_z = 16'($urandom);
      end
      8: begin
        smp.accel_x = axis_extreme();
        smp.accel_y = axis_extreme();
        smp.accel_z = axis_extreme();
      end
      default: begin
        smp.accel_x = '0;
        smp.accel_y = '0;
        smp.accel_z = '0;
      end
    endcase
    smp.reset_pressed  = ($urandom_range(0, 24) == 0);
    smp.toggle_pressed = ($urandom_range(0, 11) == 0);
    return smp;
  endfunction

  // offer one item and hold it until accepted
  task automatic push_item(input amsc_pkg::in_item_t smp);
    in_item_i  <= smp;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (!smp.reset_pressed && smp.toggle_pressed) run_shadow = ~run_shadow;
  endtask

  task automatic hold_off(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop sending until every expected result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THRESHOLD_ADDR;
    pwdata  <= amsc_pkg::PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    int          sent;
    int          burst;
    logic [15:0] thr;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    run_shadow  = 1'b0;
    full_rate   = 1'b0;
    stall_mode  = STALL_NONE;
    mode_left   = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items at the reset threshold
    push_item(make_item(16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 1'b0));  // stopped
    push_item(make_item(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b1)); // start, peak
    push_item(make_item(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0)); // no rise
    push_item(make_item(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0));              // falling
    push_item(make_item(16'sd491, 16'sd0, 16'sd0, 1'b0, 1'b0));            // rise at threshold
    push_item(make_item(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0));
    push_item(make_item(16'sd0, -16'sd492, 16'sd0, 1'b0, 1'b0));           // just above
    push_item(make_item(16'sd1, 16'sd1, 16'sd1, 1'b1, 1'b1));              // both buttons
    push_item(make_item(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0));              // reset alone
    push_item(make_item(16'sd32767, -16'sd32768, 16'sd1, 1'b0, 1'b0));
    push_item(make_item(-16'sd1, -16'sd1, -16'sd1, 1'b0, 1'b1));           // stop
    push_item(make_item(16'sd0, 16'sd0, 16'sd32767, 1'b0, 1'b0));          // stopped, held
    push_item(make_item(16'sd0, 16'sd0, -16'sd16384, 1'b0, 1'b1));         // restart
    push_item(make_item(16'sd1, -16'sd1, 16'sd0, 1'b0, 1'b0));
    push_item(make_item(16'sd12000, 16'sd12000, 16'sd12000, 1'b0, 1'b0));
    push_item(make_item(-16'sd12000, 16'sd0, 16'sd0, 1'b0, 1'b0));

    // random phases, each under its own threshold
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       thr = '0;
        1:       thr = '1;
        2:       thr = 16'($urandom_range(1, 1500));
        3:       thr = 16'd1;
        4:       thr = 16'($urandom);
        default: thr = amsc_pkg::THRESHOLD_RST;
      endcase
      drain_results();
      write_threshold(thr);
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst; k++) begin
          push_item(gait_sample());
          sent++;
        end
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: ;
          19:      drain_results();
          default: hold_off($urandom_range(1, 24));
        endcase
      end
    end

    // back-to-back rising magnitude at full rate under a zero threshold
    drain_results();
    write_threshold('0);
    full_rate <= 1'b1;
    if (!run_shadow) push_item(make_item(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1));
    push_item(make_item(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0));
    for (int i = 0; i < RAMP_ITEMS; i++)
      push_item(make_item(16'(i * RAMP_STEP), 16'sd0, 16'sd0, 1'b0, 1'b0));
    push_item(make_item(16'sd100, 16'sd0, 16'sd0, 1'b1, 1'b0));
    push_item(make_item(16'sd20000, 16'sd0, 16'sd0, 1'b0, 1'b0));
    full_rate <= 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("PASS accel_magnitude_step_counter_unit");
    end else begin
      $display("FAIL accel_magnitude_step_counter_unit");
    end
    $finish;
  end

endmodule
